[rtl/core/weekly_window_rule_table_macros.svh]
// ---------------------------------------------------------------------------
// weekly window rule table assertion macros
// concurrent checks on clk_i, quiet while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef WEEKLY_WINDOW_RULE_TABLE_MACROS_SVH
`define WEEKLY_WINDOW_RULE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// property that holds in the same cycle
`define WWRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that holds in the cycle after its trigger
`define WWRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WWRT_ASSERT(lbl, prop, msg)
`define WWRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/wwrt_pkg.sv]
// ---------------------------------------------------------------------------
// wwrt_pkg
// shared types, codes and defaults of the weekly window rule table
// ---------------------------------------------------------------------------
package wwrt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;

  typedef enum logic [1:0] {
    FN_UPSERT = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_QUERY  = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_DAYS  = 2'd1,
    STS_BAD_TIME = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0] begin_hour;
    logic [5:0] begin_minute;
    logic [4:0] finish_hour;
    logic [5:0] finish_minute;
  } window_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic clear;
    logic step;
    logic write;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  check_err;
    logic  tab_empty;
    logic  scan_done;
    logic  out_free;
  } dp_sts_t;

endpackage

[rtl/core/wwrt_dp.sv]
// ---------------------------------------------------------------------------
// wwrt_dp
// rule memory, item registers, scan pipeline and result registers
// ---------------------------------------------------------------------------
`include "weekly_window_rule_table_macros.svh"

module wwrt_dp #(
  parameter int unsigned TableDepth = wwrt_pkg::DEF_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         func_i,
  input  logic [31:0]        rule_id_i,
  input  logic [6:0]         day_mask_i,
  input  logic [4:0]         begin_hour_i,
  input  logic [5:0]         begin_minute_i,
  input  logic [4:0]         finish_hour_i,
  input  logic [5:0]         finish_minute_i,
  input  logic [9:0]         core_count_i,
  input  logic [2:0]         now_weekday_i,
  input  logic [4:0]         now_hour_i,
  input  logic [5:0]         now_minute_i,
  input  logic               best_fit_i,
  input  wwrt_pkg::dp_cmd_t  cmd_i,
  output wwrt_pkg::dp_sts_t  sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [3:0]         match_index_o,
  output logic [9:0]         match_cores_o
);

  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [CW-1:0] DepthVal = CW'(TableDepth);

  typedef struct packed {
    logic [31:0]       ident;
    logic [6:0]        days;
    wwrt_pkg::window_t win;
    logic [9:0]        cores;
  } entry_t;

  entry_t mem [TableDepth];

  // latched item
  wwrt_pkg::func_e   func_q;
  logic [31:0]       id_q;
  logic [6:0]        days_q;
  wwrt_pkg::window_t win_q;
  logic [9:0]        ccnt_q;
  logic [2:0]        wd_q;
  logic [4:0]        hr_q;
  logic [5:0]        mn_q;
  logic              best_q;

  // table and scan
  logic [CW-1:0]     total_q;
  logic [CW-1:0]     scan_q;
  logic [CW-1:0]     rd_ptr_q;
  logic              rd_vld_q;
  entry_t            rd_q;
  logic [CW-1:0]     slot_q;
  logic              hit_q;

  // working result and output register
  wwrt_pkg::status_e res_status_q;
  logic              res_found_q;
  logic [CW-1:0]     res_idx_q;
  logic [9:0]        res_cores_q;
  logic              out_valid_q;
  wwrt_pkg::status_e out_status_q;
  logic              out_found_q;
  logic [3:0]        out_idx_q;
  logic [9:0]        out_cores_q;

  logic [7:0]        days_ext;
  logic [CW-1:0]     total_inc;
  logic              day_ok, begin_ok, end_ok, q_match, id_match, stop, last;
  logic              better, is_upsert, is_query, issue, full, no_days, bad_time;
  logic              append;

  assign days_ext  = {1'b0, rd_q.days};
  assign day_ok    = days_ext[wd_q];
  assign begin_ok  = !((hr_q < rd_q.win.begin_hour) ||
                       ((hr_q == rd_q.win.begin_hour) && (mn_q < rd_q.win.begin_minute)));
  // an end hour of zero leaves later hours open
  assign end_ok    = !(((rd_q.win.finish_hour != 5'd0) && (hr_q > rd_q.win.finish_hour)) ||
                       ((hr_q == rd_q.win.finish_hour) && (mn_q > rd_q.win.finish_minute)));
  assign q_match   = day_ok && begin_ok && end_ok;
  assign id_match  = (rd_q.ident == id_q);
  assign is_upsert = (func_q == wwrt_pkg::FN_UPSERT);
  assign is_query  = (func_q == wwrt_pkg::FN_QUERY);
  assign stop      = is_upsert ? id_match : (q_match && !best_q);
  assign last      = ((rd_ptr_q + CW'(1)) == total_q);
  assign better    = q_match && (!res_found_q || (rd_q.cores > res_cores_q));
  assign issue     = cmd_i.step && (scan_q < total_q);
  assign full      = (slot_q == DepthVal);
  assign append    = cmd_i.write && !hit_q && !full;
  assign total_inc = total_q + CW'(1);
  assign no_days   = (days_q == 7'd0);
  assign bad_time  = (win_q.begin_hour > win_q.finish_hour) ||
                     ((win_q.begin_hour == win_q.finish_hour) &&
                      (win_q.begin_minute > win_q.finish_minute));

  assign sts_o.func      = func_q;
  assign sts_o.check_err = no_days || bad_time;
  assign sts_o.tab_empty = (total_q == '0);
  assign sts_o.scan_done = rd_vld_q && (stop || last);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        total_q <= '0;
      end else if (append) begin
        total_q <= total_inc;
      end
      if (cmd_i.load) begin
        scan_q   <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_q <= scan_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // rule memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && !full) begin
      mem[slot_q[AW-1:0]] <= '{ident: id_q, days: days_q, win: win_q, cores: ccnt_q};
    end
    if (issue) begin
      rd_q     <= mem[scan_q[AW-1:0]];
      rd_ptr_q <= scan_q;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= wwrt_pkg::func_e'(func_i);
      id_q         <= rule_id_i;
      days_q       <= day_mask_i;
      win_q        <= '{begin_hour: begin_hour_i, begin_minute: begin_minute_i,
                        finish_hour: finish_hour_i, finish_minute: finish_minute_i};
      ccnt_q       <= core_count_i;
      wd_q         <= now_weekday_i;
      hr_q         <= now_hour_i;
      mn_q         <= now_minute_i;
      best_q       <= best_fit_i;
      slot_q       <= total_q;
      hit_q        <= 1'b0;
      res_status_q <= wwrt_pkg::STS_OK;
      res_found_q  <= 1'b0;
      res_idx_q    <= '0;
      res_cores_q  <= '0;
    end
    // an empty day mask is reported ahead of a bad window
    if (cmd_i.check && is_upsert && (no_days || bad_time)) begin
      priority if (no_days) begin
        res_status_q <= wwrt_pkg::STS_NO_DAYS;
      end else begin
        res_status_q <= wwrt_pkg::STS_BAD_TIME;
      end
    end
    if (cmd_i.step && rd_vld_q) begin
      if (is_upsert && id_match) begin
        hit_q  <= 1'b1;
        slot_q <= rd_ptr_q;
      end
      if (is_query && better) begin
        res_found_q <= 1'b1;
        res_idx_q   <= rd_ptr_q;
        res_cores_q <= rd_q.cores;
      end
    end
    if (cmd_i.write && full) begin
      res_status_q <= wwrt_pkg::STS_FULL;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_idx_q    <= 4'(res_idx_q);
      out_cores_q  <= res_cores_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign match_index_o = out_idx_q;
  assign match_cores_o = out_cores_q;

  `WWRT_ASSERT(a_total_bound, total_q <= DepthVal, "rule count above table depth")
  `WWRT_ASSERT(a_read_in_table, !rd_vld_q || (rd_ptr_q < total_q), "scan read past last rule")
  `WWRT_ASSERT_NEXT(a_append_grows, append, total_q == $past(total_inc), "append did not grow")

endmodule

[rtl/core/wwrt_ctrl.sv]
// ---------------------------------------------------------------------------
// wwrt_ctrl
// sequencer: check, scan, write and hand-off of one item at a time
// ---------------------------------------------------------------------------
`include "weekly_window_rule_table_macros.svh"

module wwrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output wwrt_pkg::dp_cmd_t cmd_o,
  input  wwrt_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  wwrt_pkg::dp_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        unique case (sts_i.func)
          wwrt_pkg::FN_UPSERT: begin
            priority if (sts_i.check_err) begin
              state_d = S_DONE;
            end else if (sts_i.tab_empty) begin
              state_d = S_WRITE;
            end else begin
              state_d = S_SCAN;
            end
          end
          wwrt_pkg::FN_CLEAR: begin
            cmd.clear = 1'b1;
            state_d   = S_DONE;
          end
          wwrt_pkg::FN_QUERY: begin
            state_d = sts_i.tab_empty ? S_DONE : S_SCAN;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = (sts_i.func == wwrt_pkg::FN_UPSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != S_IDLE);

  `WWRT_ASSERT_NEXT(a_scan_ends, (state_q == S_SCAN) && sts_i.scan_done, state_q != S_SCAN, "scan did not end")
  `WWRT_ASSERT_NEXT(a_done_holds, (state_q == S_DONE) && !sts_i.out_free, state_q == S_DONE, "result dropped while output busy")
  `WWRT_ASSERT(a_write_upsert, (state_q != S_WRITE) || (sts_i.func == wwrt_pkg::FN_UPSERT), "table write outside upsert")

endmodule

[rtl/core/weekly_window_rule_table.sv]
// ---------------------------------------------------------------------------
// weekly_window_rule_table
// table of weekly time-window rules with upsert, clear and time query
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  --------------------------
//   in       input      in_valid_i / in_stall_o   func_i .. best_fit_i
//   out      output     out_valid_o / out_stall_i status_o, found_o,
//                                                 match_index_o, match_cores_o
//
// one item at a time; the single memory read port gives one stored rule per
// cycle to the scan, which runs up to the matching id or first hit, or over
// every stored rule for best fit; a query runs check, scan, hand-off, an
// upsert check, scan, write, hand-off; a rejected upsert, a clear, an unused
// code or an empty-table query goes from check to hand-off, an upsert into an
// empty table from check to write; the next item is taken back in idle; reset
// empties the table at once; a waiting result sits in the output register
// while the next item runs, which holds at its end under out_stall_i
//
module weekly_window_rule_table #(
  parameter int unsigned TableDepth = wwrt_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] rule_id_i,
  input  logic [6:0]  day_mask_i,
  input  logic [4:0]  begin_hour_i,
  input  logic [5:0]  begin_minute_i,
  input  logic [4:0]  finish_hour_i,
  input  logic [5:0]  finish_minute_i,
  input  logic [9:0]  core_count_i,
  input  logic [2:0]  now_weekday_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,
  input  logic        best_fit_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [3:0]  match_index_o,
  output logic [9:0]  match_cores_o
);

  // command and status between sequencer and datapath
  wwrt_pkg::dp_cmd_t cmd;
  wwrt_pkg::dp_sts_t sts;

  // sequencer: idle, check, scan, write, hand-off
  wwrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // rule memory, compare logic and the output register
  wwrt_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .rule_id_i       (rule_id_i),
    .day_mask_i      (day_mask_i),
    .begin_hour_i    (begin_hour_i),
    .begin_minute_i  (begin_minute_i),
    .finish_hour_i   (finish_hour_i),
    .finish_minute_i (finish_minute_i),
    .core_count_i    (core_count_i),
    .now_weekday_i   (now_weekday_i),
    .now_hour_i      (now_hour_i),
    .now_minute_i    (now_minute_i),
    .best_fit_i      (best_fit_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .found_o         (found_o),
    .match_index_o   (match_index_o),
    .match_cores_o   (match_cores_o)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for weekly_window_rule_table: a mirror of the rule table
// predicts the reply to every accepted item, while directed and random item
// streams drive the block under bursty input and patterned output stalls
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = wwrt_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned NUM_ITEMS     = 550;     // random items after the directed ones
  localparam int unsigned CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned ID_POOL       = 24;      // more ids than slots, so the table fills

  // one input item, typed at the port widths
  typedef struct {
    wwrt_pkg::func_e func;
    logic [31:0]     rule_id;
    logic [6:0]      day_mask;
    logic [4:0]      begin_hour;
    logic [5:0]      begin_minute;
    logic [4:0]      finish_hour;
    logic [5:0]      finish_minute;
    logic [9:0]      core_count;
    logic [2:0]      now_weekday;
    logic [4:0]      now_hour;
    logic [5:0]      now_minute;
    logic            best_fit;
  } rule_item_t;

  // one reply of the block
  typedef struct {
    wwrt_pkg::status_e status;
    logic              found;
    logic [3:0]        index;
    logic [9:0]        cores;
  } reply_t;

  // receiver stall behavior, switched at the end of each random-length phase
  typedef enum int unsigned {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN,
    RX_HEAVY
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // rule table mirror: own copy of the stored rules, predicts each reply and
  // compares the replies that come back in order
  // --------------------------------------------------------------------------
  class rule_table_mirror;
    logic [31:0]       ident [DEPTH];
    logic [6:0]        days  [DEPTH];
    wwrt_pkg::window_t win   [DEPTH];
    logic [9:0]        cores [DEPTH];
    int unsigned total = 0;
    int unsigned mismatches = 0;
    reply_t      expected_replies [$];

    // hour zero as finish hour leaves later hours open, only its minutes bound
    function bit covers(wwrt_pkg::window_t w, logic [4:0] h, logic [5:0] m);
      if (h < w.begin_hour || (h == w.begin_hour && m < w.begin_minute)) return 1'b0;
      if ((w.finish_hour != 0 && h > w.finish_hour) ||
          (h == w.finish_hour && m > w.finish_minute)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(rule_item_t it);
      reply_t      r;
      int unsigned slot;
      r = '{status: wwrt_pkg::STS_OK, found: 1'b0, index: 4'd0, cores: 10'd0};
      case (it.func)
        wwrt_pkg::FN_UPSERT: begin
          if (it.day_mask == '0) begin
            r.status = wwrt_pkg::STS_NO_DAYS;
          end else if (it.begin_hour > it.finish_hour ||
                       (it.begin_hour == it.finish_hour &&
                        it.begin_minute > it.finish_minute)) begin
            r.status = wwrt_pkg::STS_BAD_TIME;
          end else begin
            slot = total;
            for (int unsigned i = 0; i < total; i++) begin
              if (ident[i] == it.rule_id) begin
                slot = i;
                break;
              end
            end
            if (slot >= DEPTH) begin
              r.status = wwrt_pkg::STS_FULL;
            end else begin
              ident[slot] = it.rule_id;
              days[slot]  = it.day_mask;
              win[slot]   = '{it.begin_hour, it.begin_minute, it.finish_hour, it.finish_minute};
              cores[slot] = it.core_count;
              if (slot == total) total++;
            end
          end
        end
        wwrt_pkg::FN_CLEAR: total = 0;
        wwrt_pkg::FN_QUERY: begin
          // weekday seven has no mask bit and never matches
          for (int unsigned i = 0; i < total; i++) begin
            if (it.now_weekday < 3'd7 && days[i][it.now_weekday] &&
                covers(win[i], it.now_hour, it.now_minute)) begin
              // strict compare keeps the earliest rule on a core tie
              if (!r.found || (it.best_fit && cores[i] > r.cores)) begin
                r.found = 1'b1;
                r.index = 4'(i);
                r.cores = cores[i];
              end
              if (!it.best_fit) break;
            end
          end
        end
        default: ;  // unused code: plain ok reply
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with nothing expected: status %0d found %0d index %0d cores %0d",
               got.status, got.found, got.index, got.cores);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $error("match_index: expected %0d, actual %0d", want.index, got.index);
        mismatches++;
      end
      if (got.cores !== want.cores) begin
        $error("match_cores: expected %0d, actual %0d", want.cores, got.cores);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [31:0] rule_id_i;
  logic [6:0]  day_mask_i;
  logic [4:0]  begin_hour_i;
  logic [5:0]  begin_minute_i;
  logic [4:0]  finish_hour_i;
  logic [5:0]  finish_minute_i;
  logic [9:0]  core_count_i;
  logic [2:0]  now_weekday_i;
  logic [4:0]  now_hour_i;
  logic [5:0]  now_minute_i;
  logic        best_fit_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic        found_o;
  logic [3:0]  match_index_o;
  logic [9:0]  match_cores_o;

  rule_table_mirror mirror = new;

  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;  // bumped by the sender, served by the receiver
  int unsigned cycle_count   = 0;
  logic [31:0] id_pool [ID_POOL];

  weekly_window_rule_table #(
    .TableDepth(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .rule_id_i      (rule_id_i),
    .day_mask_i     (day_mask_i),
    .begin_hour_i   (begin_hour_i),
    .begin_minute_i (begin_minute_i),
    .finish_hour_i  (finish_hour_i),
    .finish_minute_i(finish_minute_i),
    .core_count_i   (core_count_i),
    .now_weekday_i  (now_weekday_i),
    .now_hour_i     (now_hour_i),
    .now_minute_i   (now_minute_i),
    .best_fit_i     (best_fit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .match_cores_o  (match_cores_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // every accepted reply goes to the mirror; values sampled before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_reply('{status: wwrt_pkg::status_e'(status_o), found: found_o,
                           index: match_index_o, cores: match_cores_o});
    end
  end

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------

  // every field random over its full width, unused fields included
  function automatic rule_item_t scramble();
    rule_item_t it;
    it.func          = wwrt_pkg::func_e'($urandom_range(0, 3));
    it.rule_id       = $urandom();
    it.day_mask      = 7'($urandom_range(0, 127));
    it.begin_hour    = 5'($urandom_range(0, 31));
    it.begin_minute  = 6'($urandom_range(0, 63));
    it.finish_hour   = 5'($urandom_range(0, 31));
    it.finish_minute = 6'($urandom_range(0, 63));
    it.core_count    = 10'($urandom_range(0, 1023));
    it.now_weekday   = 3'($urandom_range(0, 7));
    it.now_hour      = 5'($urandom_range(0, 31));
    it.now_minute    = 6'($urandom_range(0, 63));
    it.best_fit      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic rule_item_t make_upsert(logic [31:0] id, logic [6:0] mask,
                                             logic [4:0] bh, logic [5:0] bm,
                                             logic [4:0] fh, logic [5:0] fm,
                                             logic [9:0] cc);
    rule_item_t it;
    it = scramble();
    it.func          = wwrt_pkg::FN_UPSERT;
    it.rule_id       = id;
    it.day_mask      = mask;
    it.begin_hour    = bh;
    it.begin_minute  = bm;
    it.finish_hour   = fh;
    it.finish_minute = fm;
    it.core_count    = cc;
    return it;
  endfunction

  function automatic rule_item_t make_query(logic [2:0] wd, logic [4:0] h, logic [5:0] m,
                                            logic best);
    rule_item_t it;
    it = scramble();
    it.func        = wwrt_pkg::FN_QUERY;
    it.now_weekday = wd;
    it.now_hour    = h;
    it.now_minute  = m;
    it.best_fit    = best;
    return it;
  endfunction

  function automatic rule_item_t make_op(wwrt_pkg::func_e f);
    rule_item_t it;
    it = scramble();
    it.func = f;
    return it;
  endfunction

  // mostly well-formed rule from the id pool, now and then a rejected one
  function automatic rule_item_t make_rule();
    rule_item_t it;
    it = make_op(wwrt_pkg::FN_UPSERT);
    it.rule_id  = id_pool[$urandom_range(0, ID_POOL - 1)];
    it.day_mask = 7'($urandom_range(1, 127));
    if ($urandom_range(0, 7) == 0) begin
      // open hours window
      it.begin_hour    = 5'd0;
      it.finish_hour   = 5'd0;
      it.begin_minute  = 6'($urandom_range(0, 59));
      it.finish_minute = 6'($urandom_range(it.begin_minute, 59));
    end else begin
      it.begin_hour    = 5'($urandom_range(0, 23));
      it.finish_hour   = 5'($urandom_range(it.begin_hour, 23));
      it.begin_minute  = 6'($urandom_range(0, 59));
      it.finish_minute = (it.finish_hour == it.begin_hour) ?
                         6'($urandom_range(it.begin_minute, 59)) : 6'($urandom_range(0, 59));
    end
    // a few core values repeat so best-fit ties come up
    if ($urandom_range(0, 1) == 0) it.core_count = 10'($urandom_range(0, 3) * 341);
    case ($urandom_range(0, 19))
      0: it.day_mask = '0;
      1: it.begin_hour = it.finish_hour + 5'd1;
      2: begin
        it.finish_hour   = it.begin_hour;
        it.begin_minute  = 6'($urandom_range(1, 63));
        it.finish_minute = it.begin_minute - 6'd1;
      end
      default: ;
    endcase
    return it;
  endfunction

  // query aimed at a stored rule, often right on its window edges
  function automatic rule_item_t make_probe();
    rule_item_t        it;
    int unsigned       k;
    wwrt_pkg::window_t w;
    logic [4:0]        top;
    it = make_op(wwrt_pkg::FN_QUERY);
    if (mirror.total == 0 || $urandom_range(0, 4) == 0) return it;
    k = $urandom_range(0, mirror.total - 1);
    w = mirror.win[k];
    do it.now_weekday = 3'($urandom_range(0, 6));
    while (!mirror.days[k][it.now_weekday]);
    top = (w.finish_hour == 0) ? 5'd23 : w.finish_hour;
    it.now_hour = 5'($urandom_range(w.begin_hour, top));
    case ($urandom_range(0, 2))
      0: it.now_minute = w.begin_minute;
      1: it.now_minute = w.finish_minute;
      default: it.now_minute = 6'($urandom_range(0, 59));
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic present(rule_item_t it);
    func_i          <= it.func;
    rule_id_i       <= it.rule_id;
    day_mask_i      <= it.day_mask;
    begin_hour_i    <= it.begin_hour;
    begin_minute_i  <= it.begin_minute;
    finish_hour_i   <= it.finish_hour;
    finish_minute_i <= it.finish_minute;
    core_count_i    <= it.core_count;
    now_weekday_i   <= it.now_weekday;
    now_hour_i      <= it.now_hour;
    now_minute_i    <= it.now_minute;
    best_fit_i      <= it.best_fit;
  endtask

  // offer one item until taken, then maybe close the burst with a gap
  task automatic send_item(rule_item_t it);
    present(it);
    in_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (in_stall_o);
    mirror.note_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // occasional long bursts give stretches with no input idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // hold input until every outstanding reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (mirror.pending() != 0);
  endtask

  task automatic run_directed();
    send_item(make_query(3'd2, 5'd12, 6'd0, 1'b0));                               // empty table
    send_item(make_upsert(32'h1, 7'h00, 5'd1, 6'd0, 5'd0, 6'd0, 10'd5));          // no days wins over bad time
    send_item(make_upsert(32'h1, 7'h01, 5'd10, 6'd0, 5'd9, 6'd59, 10'd5));        // begin hour after finish
    send_item(make_upsert(32'h1, 7'h01, 5'd9, 6'd31, 5'd9, 6'd30, 10'd5));        // same hour, minute after
    send_item(make_upsert(32'hFFFF_FFFF, 7'h7F, 5'd0, 6'd0, 5'd23, 6'd59, 10'd1)); // whole week
    send_item(make_upsert(32'h0, 7'h41, 5'd0, 6'd15, 5'd0, 6'd45, 10'd1023));     // open hours, weekend
    send_item(make_upsert(32'h1, 7'h3E, 5'd31, 6'd63, 5'd31, 6'd63, 10'd0));      // out of range instant
    send_item(make_query(3'd0, 5'd15, 6'd0, 1'b0));                               // first match
    send_item(make_query(3'd0, 5'd15, 6'd0, 1'b1));                               // best fit, open hours
    send_item(make_query(3'd0, 5'd0, 6'd50, 1'b1));                               // past hour zero bound
    send_item(make_upsert(32'hFFFF_FFFF, 7'h7F, 5'd0, 6'd0, 5'd23, 6'd59, 10'd1023)); // update in place
    send_item(make_query(3'd6, 5'd7, 6'd0, 1'b1));                                // core tie, earliest wins
    send_item(make_query(3'd7, 5'd7, 6'd0, 1'b0));                                // weekday seven
    send_item(make_query(3'd3, 5'd31, 6'd63, 1'b0));                              // out of range time
    send_item(make_op(wwrt_pkg::FN_NONE));
    send_item(make_op(wwrt_pkg::FN_CLEAR));
    send_item(make_query(3'd0, 5'd12, 6'd0, 1'b1));                               // after clear
  endtask

  task automatic run_random();
    int unsigned scenario;
    int unsigned goal;
    int unsigned n;
    scenario = 0;
    goal = items_sent + NUM_ITEMS;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int unsigned i = 2; i < ID_POOL; i++) id_pool[i] = $urandom();
    while (items_sent < goal) begin
      // long receiver hold-off while items keep coming, block fills up
      if (scenario == 2) hold_requests <= hold_requests + 1;
      if (scenario == 5 || $urandom_range(0, 9) == 0) drain_replies();
      if (scenario != 2 && $urandom_range(0, 4) == 0) begin
        // noise: anything the ports allow
        repeat ($urandom_range(1, 4)) send_item(scramble());
      end else begin
        if ($urandom_range(0, 3) == 0) send_item(make_op(wwrt_pkg::FN_CLEAR));
        n = $urandom_range(4, 20);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) send_item(make_probe());
          else send_item(make_rule());
        end
      end
      scenario++;
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: own stall pattern plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    stall_mode_e mode;
    int unsigned phase_left;
    int unsigned holds_served;
    mode = RX_FREE;
    phase_left = 0;
    holds_served = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        case (mode)
          RX_FREE:    out_stall_i <= 1'b0;
          RX_RANDOM:  out_stall_i <= ($urandom_range(0, 99) < 30);
          RX_PATTERN: out_stall_i <= ((phase_left % 7) < 4);
          default:    out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    present(scramble());
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    drain_replies();
    // let a stray extra reply show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wwrt_pkg.sv
rtl/core/wwrt_dp.sv
rtl/core/wwrt_ctrl.sv
rtl/core/weekly_window_rule_table.sv
bench/tb.sv
